// ----- rtl/core/rgb_to_hsv_8bit_macros.svh -----
// Assertion macros for the RGB to HSV converter.
// Used by the checker file; no other dependencies.
`ifndef RGB_TO_HSV_8BIT_MACROS_SVH
`define RGB_TO_HSV_8BIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RTH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_8bit check failed");

// next-cycle implication, disabled in reset
`define RTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_8bit check failed");

`endif

// ----- rtl/core/rth_pkg.sv -----
// Shared constants and pipeline word types for the RGB to HSV converter.
// No dependencies.
package rth_pkg;

  localparam int PIX_W     = 8;                // channel width
  localparam int QUO_W     = PIX_W;            // quotient bits, one per divider stage
  localparam int DIV_STEPS = QUO_W;
  localparam int POS_W     = PIX_W + 3;        // hue position, < 6*delta
  localparam int DIV_W     = POS_W + PIX_W;    // 255*pos and divisor << (QUO_W-1)

  // after the max/min stage
  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] delta;
    logic [POS_W-1:0] pos;
  } front_word_t;

  // word carried through the divider stages
  typedef struct packed {
    logic [DIV_W-1:0] hue_rem;
    logic [DIV_W-1:0] hue_dsh;
    logic [QUO_W-1:0] hue_q;
    logic [DIV_W-1:0] sat_rem;
    logic [DIV_W-1:0] sat_dsh;
    logic [QUO_W-1:0] sat_q;
    logic [PIX_W-1:0] brightness;
  } div_word_t;

endpackage

// ----- rtl/core/rth_if.sv -----
// Valid/ready channel interfaces for pixel words in and HSV words out.
// Depends on rth_pkg.
interface rth_in_if;
  import rth_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rth_out_if;
  import rth_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] hue;
  logic [PIX_W-1:0] saturation;
  logic [PIX_W-1:0] brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ----- rtl/core/rth_front.sv -----
// Front end: max/min/hue position stage, then the x255 and divisor setup stage.
// Depends on rth_pkg.
module rth_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic [rth_pkg::PIX_W-1:0] red,
  input  logic [rth_pkg::PIX_W-1:0] green,
  input  logic [rth_pkg::PIX_W-1:0] blue,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output rth_pkg::div_word_t       dn_data
);
  import rth_pkg::*;

  logic             a_v_r, b_v_r;
  logic             a_adv, b_adv;
  front_word_t      a_r, a_nxt;
  div_word_t        b_r, b_nxt;
  logic [PIX_W-1:0] mx, mn;
  logic [POS_W-1:0] d_ext;
  logic [POS_W-1:0] d6;

  assign b_adv    = !b_v_r || dn_ready;
  assign a_adv    = !a_v_r || b_adv;
  assign up_ready = a_adv;
  assign dn_valid = b_v_r;
  assign dn_data  = b_r;

  // stage A: max, min, delta and position within [0, 6*delta)
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    a_nxt.mx    = mx;
    a_nxt.delta = mx - mn;
    d_ext       = POS_W'(a_nxt.delta);
    // sums are modular in POS_W bits; true values stay in range
    if (mx == red) begin
      if (green >= blue) begin
        a_nxt.pos = POS_W'(green) - POS_W'(blue);
      end else begin
        a_nxt.pos = (d_ext << 2) + (d_ext << 1) + POS_W'(green) - POS_W'(blue);
      end
    end else if (mx == green) begin
      a_nxt.pos = (d_ext << 1) + POS_W'(blue) - POS_W'(red);
    end else begin
      a_nxt.pos = (d_ext << 2) + POS_W'(red) - POS_W'(green);
    end
  end

  // stage B: dividends times 255, divisors aligned to the top quotient bit
  always_comb begin
    d6 = (POS_W'(a_r.delta) << 2) + (POS_W'(a_r.delta) << 1);
    b_nxt.hue_rem    = (DIV_W'(a_r.pos) << PIX_W) - DIV_W'(a_r.pos);
    b_nxt.sat_rem    = (DIV_W'(a_r.delta) << PIX_W) - DIV_W'(a_r.delta);
    b_nxt.hue_q      = '0;
    b_nxt.sat_q      = '0;
    b_nxt.brightness = a_r.mx;
    if (a_r.delta == '0) begin
      // gray: zero dividend over a nonzero divisor gives zero
      b_nxt.hue_dsh = DIV_W'(1) << (QUO_W - 1);
      b_nxt.sat_dsh = DIV_W'(1) << (QUO_W - 1);
    end else begin
      b_nxt.hue_dsh = DIV_W'(d6) << (QUO_W - 1);
      b_nxt.sat_dsh = DIV_W'(a_r.mx) << (QUO_W - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= up_valid;
      if (b_adv) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && up_valid) a_r <= a_nxt;
    if (b_adv && a_v_r) b_r <= b_nxt;
  end

endmodule

// ----- rtl/core/rth_div_stage.sv -----
// One restoring-division step for both hue and saturation quotients.
// Depends on rth_pkg.
module rth_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rth_pkg::div_word_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rth_pkg::div_word_t dn_data
);
  import rth_pkg::*;

  logic             v_r;
  logic             adv;
  div_word_t        d_r, d_nxt;
  logic             hue_ge, sat_ge;
  logic [DIV_W-1:0] hue_diff, sat_diff;

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // remainder stays below 2x the aligned divisor, so the shift drops nothing
  always_comb begin
    hue_ge   = up_data.hue_rem >= up_data.hue_dsh;
    sat_ge   = up_data.sat_rem >= up_data.sat_dsh;
    hue_diff = hue_ge ? up_data.hue_rem - up_data.hue_dsh : up_data.hue_rem;
    sat_diff = sat_ge ? up_data.sat_rem - up_data.sat_dsh : up_data.sat_rem;
    d_nxt            = up_data;
    d_nxt.hue_rem    = {hue_diff[DIV_W-2:0], 1'b0};
    d_nxt.sat_rem    = {sat_diff[DIV_W-2:0], 1'b0};
    d_nxt.hue_q      = {up_data.hue_q[QUO_W-2:0], hue_ge};
    d_nxt.sat_q      = {up_data.sat_q[QUO_W-2:0], sat_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) d_r <= d_nxt;
  end

endmodule

// ----- rtl/core/rgb_to_hsv_8bit.sv -----
// RGB to HSV converter, 8 bits per channel: front end plus divider pipeline.
// Depends on rth_pkg, rth_if, rth_front, rth_div_stage.
//
//   channel  dir  word                        handshake
//   in_pix   in   red, green, blue            valid/ready
//   out_pix  out  hue, saturation, brightness valid/ready
//
// One pixel per clock sustained while out_pix.ready holds; registers from accept to out valid:
// two front stages (max/min, x255 setup) and one stage per quotient bit.
// Each stage has its own valid bit and register, so bubbles close up under stall.
// Synchronous active-low reset clears the valid bits only.
module rgb_to_hsv_8bit (
  input  logic       clk,
  input  logic       rst_n,
  rth_in_if.sink     in_pix,
  rth_out_if.source  out_pix
);
  import rth_pkg::*;

  logic      st_valid [DIV_STEPS+1];
  logic      st_ready [DIV_STEPS+1];
  div_word_t st_data  [DIV_STEPS+1];

  rth_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_pix.valid),
    .up_ready (in_pix.ready),
    .red      (in_pix.red),
    .green    (in_pix.green),
    .blue     (in_pix.blue),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rth_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up_data  (st_data[i]),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn_data  (st_data[i+1])
    );
  end

  assign st_ready[DIV_STEPS] = out_pix.ready;
  assign out_pix.valid       = st_valid[DIV_STEPS];
  assign out_pix.hue         = st_data[DIV_STEPS].hue_q;
  assign out_pix.saturation  = st_data[DIV_STEPS].sat_q;
  assign out_pix.brightness  = st_data[DIV_STEPS].brightness;

endmodule

// ----- rtl/core/rth_checker.sv -----
// Port-level checks on the converter's result channel, bound to the top level.
// Depends on rth_pkg and rgb_to_hsv_8bit_macros.svh.
`include "rgb_to_hsv_8bit_macros.svh"

module rth_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rth_pkg::PIX_W-1:0] hue,
  input logic [rth_pkg::PIX_W-1:0] saturation,
  input logic [rth_pkg::PIX_W-1:0] brightness
);
  import rth_pkg::*;

  // a stalled word stays offered
  `RTH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // zero saturation only for gray, and gray has zero hue
  `RTH_ASSERT_IMPLY(a_gray_hue, clk, rst_n, out_valid && saturation == '0, hue == '0)
  // black is gray
  `RTH_ASSERT_IMPLY(a_black_sat, clk, rst_n, out_valid && brightness == '0, saturation == '0)
  // hue wraps before a full turn
  `RTH_ASSERT_IMPLY(a_hue_range, clk, rst_n, out_valid, hue != {PIX_W{1'b1}})

endmodule

bind rgb_to_hsv_8bit rth_checker u_rth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_pix.valid),
  .out_ready  (out_pix.ready),
  .hue        (out_pix.hue),
  .saturation (out_pix.saturation),
  .brightness (out_pix.brightness)
);

// ----- test/tb_rgb_to_hsv_8bit.sv -----
// Testbench for the 8-bit RGB to HSV converter.
// Checks each output word against a built-in HSV predictor.
// Depends on rth_pkg, rth_if and rgb_to_hsv_8bit.
module tb_rgb_to_hsv_8bit;
  timeunit 1ns;
  timeprecision 1ps;

  import rth_pkg::*;

  localparam int RANDOM_PIXELS = 1600;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 30;   // leave room for stray words
  localparam int MAX_PRINTS    = 40;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } hsv_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;

  rth_in_if  in_pix();
  rth_out_if out_pix();

  rgb_to_hsv_8bit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  rgb_t        pixels_to_send[$];
  hsv_t        hsv_expected[$];
  int          pixels_total;
  int          pixels_sent;
  int          mismatches;
  int          cycle_count;
  bit          in_taken;
  int          gap_left;
  int          burst_left;
  rx_mode_t    rx_mode;
  int          rx_left;
  int          rx_phase;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hue sector picks red, then green, then blue on ties
  function automatic hsv_t hsv_of(rgb_t px);
    int unsigned r, g, b, mx, mn, delta, pos;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    res.brightness = PIX_W'(mx);
    res.hue = '0;
    res.saturation = '0;
    if (delta != 0) begin
      if (mx == r) begin
        pos = (g >= b) ? g - b : 6 * delta - (b - g);
      end else if (mx == g) begin
        pos = 2 * delta + b - r;
      end else begin
        pos = 4 * delta + r - g;
      end
      res.hue = PIX_W'((255 * pos) / (6 * delta));
      res.saturation = PIX_W'((255 * delta) / mx);
    end
    return res;
  endfunction

  function automatic rgb_t make_rgb(int r, int g, int b);
    rgb_t px;
    px.red = PIX_W'(r);
    px.green = PIX_W'(g);
    px.blue = PIX_W'(b);
    return px;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 254;
      default: return 255;
    endcase
  endfunction

  // mostly uniform, with extra weight on near-gray, tied and extreme pixels
  function automatic rgb_t random_pixel();
    int base, v, w;
    case ($urandom_range(0, 9))
      6: begin
        base = $urandom_range(0, 255);
        return make_rgb((base + $urandom_range(0, 3)) > 255 ? 255 : base + $urandom_range(0, 3),
                        (base + $urandom_range(0, 3)) > 255 ? 255 : base + $urandom_range(0, 3),
                        (base + $urandom_range(0, 3)) > 255 ? 255 : base + $urandom_range(0, 3));
      end
      7: begin
        v = $urandom_range(0, 255);
        w = $urandom_range(0, 255);
        case ($urandom_range(0, 2))
          0: return make_rgb(v, v, w);
          1: return make_rgb(w, v, v);
          default: return make_rgb(v, w, v);
        endcase
      end
      8: return make_rgb(edge_value(), edge_value(), edge_value());
      9: begin
        v = $urandom_range(0, 255);
        w = $urandom_range(0, 255);
        return make_rgb(v, v, ($urandom_range(0, 1) == 0) ? v : w);
      end
      default: return make_rgb($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    mismatches++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin : sample_channels
    rgb_t px;
    hsv_t want;
    cycle_count++;
    in_taken = rst_n && in_pix.valid && in_pix.ready;
    if (in_taken) begin
      px.red = in_pix.red;
      px.green = in_pix.green;
      px.blue = in_pix.blue;
      hsv_expected.push_back(hsv_of(px));
      pixels_sent++;
    end
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (hsv_expected.size() == 0) begin
        report_mismatch("unexpected word, hue", 0, out_pix.hue);
      end else begin
        want = hsv_expected.pop_front();
        if (out_pix.hue !== want.hue)
          report_mismatch("hue", want.hue, out_pix.hue);
        if (out_pix.saturation !== want.saturation)
          report_mismatch("saturation", want.saturation, out_pix.saturation);
        if (out_pix.brightness !== want.brightness)
          report_mismatch("brightness", want.brightness, out_pix.brightness);
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin : drive_pixels
    rgb_t px;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
    end else if (!in_pix.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_pix.valid <= 1'b0;
      end else if (pixels_to_send.size() > 0) begin
        px = pixels_to_send.pop_front();
        in_pix.red <= px.red;
        in_pix.green <= px.green;
        in_pix.blue <= px.blue;
        in_pix.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_pix.valid <= 1'b0;
      end
    end
  end

  // receiver: stall behavior switches between a few modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_FREE:  out_pix.ready <= 1'b1;
      RX_LIGHT: out_pix.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_pix.ready <= ($urandom_range(0, 3) == 0);
      default:  out_pix.ready <= (rx_phase % 3 == 0);
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_pix.valid = 1'b0;
    in_pix.red = '0;
    in_pix.green = '0;
    in_pix.blue = '0;
    out_pix.ready = 1'b0;
    in_taken = 1'b0;
    gap_left = 0;
    burst_left = 1;
    rx_left = 0;
    rx_phase = 0;
    rx_mode = RX_FREE;
    pixels_sent = 0;
    mismatches = 0;
    cycle_count = 0;

    // gray, black and white, primaries
    pixels_to_send.push_back(make_rgb(0, 0, 0));
    pixels_to_send.push_back(make_rgb(255, 255, 255));
    pixels_to_send.push_back(make_rgb(128, 128, 128));
    pixels_to_send.push_back(make_rgb(255, 0, 0));
    pixels_to_send.push_back(make_rgb(0, 255, 0));
    pixels_to_send.push_back(make_rgb(0, 0, 255));
    // ties between the largest channels
    pixels_to_send.push_back(make_rgb(255, 255, 0));
    pixels_to_send.push_back(make_rgb(0, 255, 255));
    pixels_to_send.push_back(make_rgb(255, 0, 255));
    // red largest with blue above green: hue wraps to the top
    pixels_to_send.push_back(make_rgb(255, 0, 1));
    pixels_to_send.push_back(make_rgb(255, 254, 255));
    // one-step deltas and tiny max, then mixed hues
    pixels_to_send.push_back(make_rgb(1, 0, 0));
    pixels_to_send.push_back(make_rgb(0, 1, 0));
    pixels_to_send.push_back(make_rgb(0, 0, 1));
    pixels_to_send.push_back(make_rgb(1, 1, 0));
    pixels_to_send.push_back(make_rgb(255, 254, 254));
    pixels_to_send.push_back(make_rgb(254, 255, 255));
    pixels_to_send.push_back(make_rgb(200, 100, 50));
    pixels_to_send.push_back(make_rgb(50, 200, 100));
    pixels_to_send.push_back(make_rgb(100, 50, 200));
    pixels_to_send.push_back(make_rgb(170, 85, 255));
    pixels_to_send.push_back(make_rgb(85, 170, 0));
    for (int i = 0; i < RANDOM_PIXELS; i++)
      pixels_to_send.push_back(random_pixel());
    pixels_total = pixels_to_send.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pixels_sent < pixels_total) @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && hsv_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/rth_pkg.sv
rtl/core/rth_if.sv
rtl/core/rth_front.sv
rtl/core/rth_div_stage.sv
rtl/core/rgb_to_hsv_8bit.sv
rtl/core/rth_checker.sv
test/tb_rgb_to_hsv_8bit.sv
